// ----- rtl/core/aftoff_pkg.sv -----
`timescale 1ns / 1ps

package aftoff_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 27;

    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_STEP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_FREQ      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM_LEVEL       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_TUNE_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_VFO       = 3'd4;

    localparam logic [13:0] RST_NORMAL_STEP = 14'd50;
    localparam logic [26:0] RST_CENTER_FREQ = 27'd7100000;

    localparam logic [31:0] GAP_QUICK_MS  = 32'd30;
    localparam logic [31:0] GAP_CANCEL_MS = 32'd400;
    localparam logic [2:0]  QUICK_TRIGGER = 3'd4;
    localparam logic [13:0] FAST_STEP     = 14'd500;

    localparam logic signed [19:0] OFFSET_MAX = 20'sd262143;
    localparam logic signed [19:0] OFFSET_MIN = -20'sd262144;
    localparam logic signed [28:0] FREQ_MAX   = 29'sd134217727;

    localparam logic [16:0]        WIN_HI_ZOOM = 17'd95000;
    localparam logic [16:0]        WIN_LO_ZOOM = 17'd93000;
    localparam logic signed [19:0] WIN_HI_WIDE = 20'sd142000;
    localparam logic signed [19:0] WIN_LO_WIDE = -20'sd43000;

    typedef struct packed {
        logic [13:0] normal_step;
        logic [26:0] center_freq;
        logic [2:0]  zoom_level;
        logic        fast_tune_enable;
        logic        active_vfo;
    } t_cfg;

    typedef struct packed {
        logic        func;
        logic        direction;
        logic [31:0] time_ms;
    } t_item;

    typedef struct packed {
        logic signed [18:0] offset_hz;
        logic [26:0]        tuned_freq;
        logic               vfo_slot;
        logic               recenter_request;
        logic               fast_active;
        logic [13:0]        step_in_use;
    } t_result;

endpackage

// ----- rtl/core/aftoff_if.sv -----
`timescale 1ns / 1ps

interface aftoff_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [aftoff_pkg::CFG_IDX_W-1:0]  index;
    logic [aftoff_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

interface aftoff_item_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic        direction;
    logic [31:0] time_ms;

    modport source (output valid, output func, output direction, output time_ms, input ready);
    modport sink (input valid, input func, input direction, input time_ms, output ready);
endinterface

interface aftoff_result_if;
    logic               valid;
    logic               ready;
    logic signed [18:0] offset_hz;
    logic [26:0]        tuned_freq;
    logic               vfo_slot;
    logic               recenter_request;
    logic               fast_active;
    logic [13:0]        step_in_use;

    modport source (output valid, output offset_hz, output tuned_freq, output vfo_slot,
                    output recenter_request, output fast_active, output step_in_use,
                    input ready);
    modport sink (input valid, input offset_hz, input tuned_freq, input vfo_slot,
                  input recenter_request, input fast_active, input step_in_use,
                  output ready);
endinterface

// ----- rtl/core/accelerated_fine_tune_offset_core.sv -----
`timescale 1ns / 1ps

// Accelerated fine tuning offset. Each request on the item channel is one encoder detent or
// one clear-offset command, and it yields exactly one result request, pushed into the
// result queue on acceptance. The block accepts one item every cycle: the offset,
// timestamp and fast-mode state are registered; a two-entry result queue keeps the input
// open until two results are waiting for the sink, at which point the input stalls until
// one of them is taken. Configuration writes are always ready.

module accelerated_fine_tune_offset_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    aftoff_cfg_if.sink       i_cfg,
    aftoff_item_if.sink      i_item,
    aftoff_result_if.source  o_result
);

    aftoff_pkg::t_cfg    cfg;
    aftoff_pkg::t_item   item;
    aftoff_pkg::t_result result;
    logic                not_full;
    logic                accept;

    assign item.func      = i_item.func;
    assign item.direction = i_item.direction;
    assign item.time_ms   = i_item.time_ms;
    assign i_item.ready   = not_full;
    assign accept         = i_item.valid && not_full;

    aftoff_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    aftoff_update u_update (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    aftoff_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_data     (result),
        .o_not_full (not_full),
        .o_result   (o_result)
    );

endmodule

// ----- rtl/core/aftoff_cfg_regs.sv -----
`timescale 1ns / 1ps

module aftoff_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    aftoff_cfg_if.sink        i_cfg,
    output aftoff_pkg::t_cfg  o_cfg
);

    aftoff_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.normal_step      <= aftoff_pkg::RST_NORMAL_STEP;
            r_cfg.center_freq      <= aftoff_pkg::RST_CENTER_FREQ;
            r_cfg.zoom_level       <= 3'd0;
            r_cfg.fast_tune_enable <= 1'b1;
            r_cfg.active_vfo       <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                aftoff_pkg::CFG_NORMAL_STEP:      r_cfg.normal_step      <= i_cfg.data[13:0];
                aftoff_pkg::CFG_CENTER_FREQ:      r_cfg.center_freq      <= i_cfg.data[26:0];
                aftoff_pkg::CFG_ZOOM_LEVEL:       r_cfg.zoom_level       <= i_cfg.data[2:0];
                aftoff_pkg::CFG_FAST_TUNE_ENABLE: r_cfg.fast_tune_enable <= i_cfg.data[0];
                aftoff_pkg::CFG_ACTIVE_VFO:       r_cfg.active_vfo       <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/aftoff_update.sv -----
`timescale 1ns / 1ps

module aftoff_update (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  aftoff_pkg::t_item    i_item,
    input  aftoff_pkg::t_cfg     i_cfg,
    output aftoff_pkg::t_result  o_result
);

    logic signed [18:0] r_offset;
    logic [31:0]        r_last_time;
    logic               r_fast;
    logic [1:0]         r_qcount;

    logic signed [18:0] n_offset;
    logic [31:0]        n_last_time;
    logic               n_fast;
    logic [1:0]         n_qcount;

    logic [31:0]        gap;
    logic [2:0]         cnt;
    logic [13:0]        step;
    logic signed [19:0] off_w;
    logic signed [19:0] step_w;
    logic signed [19:0] sum_w;
    logic signed [28:0] freq_w;
    logic [16:0]        win_hi;
    logic [16:0]        win_lo;
    logic signed [19:0] n_off_w;
    logic               out_win;

    always_comb begin
        gap         = i_item.time_ms - r_last_time;
        cnt         = {1'b0, r_qcount} + {2'b00, (gap <= aftoff_pkg::GAP_QUICK_MS)};
        n_offset    = r_offset;
        n_last_time = r_last_time;
        n_fast      = r_fast;
        n_qcount    = r_qcount;
        step        = 14'd0;
        off_w       = {r_offset[18], r_offset};
        step_w      = 20'sd0;
        sum_w       = off_w;

        if (i_item.func) begin
            n_offset = 19'sd0;
        end else begin
            n_last_time = i_item.time_ms;
            if (!i_cfg.fast_tune_enable) begin
                n_fast = 1'b0;
            end else if (r_fast) begin
                if (gap >= aftoff_pkg::GAP_CANCEL_MS) begin
                    n_fast = 1'b0;
                end
            end else if (cnt == aftoff_pkg::QUICK_TRIGGER) begin
                n_fast   = 1'b1;
                n_qcount = 2'd0;
            end else begin
                n_qcount = cnt[1:0];
            end

            step   = n_fast ? aftoff_pkg::FAST_STEP : i_cfg.normal_step;
            step_w = $signed({6'b0, step});
            sum_w  = i_item.direction ? (off_w - step_w) : (off_w + step_w);
            if (sum_w > aftoff_pkg::OFFSET_MAX) begin
                n_offset = aftoff_pkg::OFFSET_MAX[18:0];
            end else if (sum_w < aftoff_pkg::OFFSET_MIN) begin
                n_offset = aftoff_pkg::OFFSET_MIN[18:0];
            end else begin
                n_offset = sum_w[18:0];
            end
        end
    end

    always_comb begin
        n_off_w = {n_offset[18], n_offset};
        win_hi  = aftoff_pkg::WIN_HI_ZOOM >> i_cfg.zoom_level;
        win_lo  = aftoff_pkg::WIN_LO_ZOOM >> i_cfg.zoom_level;
        if (i_cfg.zoom_level != 3'd0) begin
            out_win = (n_off_w >= $signed({3'b000, win_hi}))
                   || (n_off_w < -$signed({3'b000, win_lo}));
        end else begin
            out_win = (n_off_w > aftoff_pkg::WIN_HI_WIDE) || (n_off_w < aftoff_pkg::WIN_LO_WIDE);
        end

        freq_w = $signed({2'b00, i_cfg.center_freq}) + $signed({{10{n_offset[18]}}, n_offset});

        o_result.offset_hz = n_offset;
        if (freq_w < 29'sd0) begin
            o_result.tuned_freq = 27'd0;
        end else if (freq_w > aftoff_pkg::FREQ_MAX) begin
            o_result.tuned_freq = aftoff_pkg::FREQ_MAX[26:0];
        end else begin
            o_result.tuned_freq = freq_w[26:0];
        end
        o_result.vfo_slot         = i_cfg.active_vfo;
        o_result.recenter_request = out_win;
        o_result.fast_active      = n_fast;
        o_result.step_in_use      = step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= 19'sd0;
            r_last_time <= 32'd0;
            r_fast      <= 1'b0;
            r_qcount    <= 2'd0;
        end else if (i_accept) begin
            r_offset    <= n_offset;
            r_last_time <= n_last_time;
            r_fast      <= n_fast;
            r_qcount    <= n_qcount;
        end
    end

endmodule

// ----- rtl/core/aftoff_out_buf.sv -----
`timescale 1ns / 1ps

module aftoff_out_buf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  aftoff_pkg::t_result  i_data,
    output logic                 o_not_full,
    aftoff_result_if.source      o_result
);

    aftoff_pkg::t_result r_mem [0:1];
    logic                r_wr_ptr;
    logic                r_rd_ptr;
    logic [1:0]          r_count;

    logic                pop;
    aftoff_pkg::t_result head;

    assign o_not_full     = (r_count != 2'd2);
    assign o_result.valid = (r_count != 2'd0);
    assign pop            = o_result.valid && o_result.ready;
    assign head           = r_mem[r_rd_ptr];

    assign o_result.offset_hz        = head.offset_hz;
    assign o_result.tuned_freq       = head.tuned_freq;
    assign o_result.vfo_slot         = head.vfo_slot;
    assign o_result.recenter_request = head.recenter_request;
    assign o_result.fast_active      = head.fast_active;
    assign o_result.step_in_use      = head.step_in_use;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/core/aftoff_checker.sv -----
`timescale 1ns / 1ps

module aftoff_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic signed [18:0] i_offset_hz,
    input logic              i_recenter_request,
    input logic              i_fast_active,
    input logic [13:0]       i_step_in_use
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("accepted item produced no pending result");

    a_zero_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_offset_hz == 19'sd0)) |-> !i_recenter_request)
        else $error("recenter request raised on a zero offset");

    a_fast_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_fast_active && (i_step_in_use != 14'd0))
        |-> (i_step_in_use == aftoff_pkg::FAST_STEP))
        else $error("fast mode detent without the fast step");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result request withdrawn while stalled");

endmodule

bind accelerated_fine_tune_offset_core aftoff_checker u_aftoff_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_item.valid),
    .i_in_ready         (i_item.ready),
    .i_out_valid        (o_result.valid),
    .i_out_ready        (o_result.ready),
    .i_offset_hz        (o_result.offset_hz),
    .i_recenter_request (o_result.recenter_request),
    .i_fast_active      (o_result.fast_active),
    .i_step_in_use      (o_result.step_in_use)
);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int CLK_HALF     = 4;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_PHASE   = 8;
    localparam int N_PHASES     = 9;
    localparam int N_DIRECTED   = 20;
    localparam int CFG_W        = aftoff_pkg::CFG_DATA_W;

    localparam logic FUNC_DETENT = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;
    localparam logic DIR_UP      = 1'b0;
    localparam logic DIR_DOWN    = 1'b1;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        logic                func;
        logic                dir;
        logic [31:0]         time_ms;
        logic                typed;
        aftoff_pkg::t_result want;
    } t_detent_row;

    typedef struct packed {
        aftoff_pkg::t_cfg regs;
        t_idle_mode       mode;
        logic [6:0]       clear_pct;
        logic [6:0]       flip_pct;
        logic [11:0]      n_items;
    } t_tune_phase;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    aftoff_cfg_if    cfg_if ();
    aftoff_item_if   item_if ();
    aftoff_result_if res_if ();

    accelerated_fine_tune_offset_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_if),
        .i_item   (item_if),
        .o_result (res_if)
    );

    aftoff_pkg::t_cfg regs_shadow;
    int               tuned_offset;
    logic [31:0]      last_detent_ms;
    logic             fast_on;
    logic [1:0]       quick_cnt;

    aftoff_pkg::t_result expected_tunes[$];
    t_detent_row         directed_rows[N_DIRECTED];
    t_tune_phase         phases[N_PHASES];

    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          hold_req = 0;
    int          mismatches = 0;
    int          results_checked = 0;
    int          requests_sent = 0;
    logic [31:0] stamp_ms = '0;
    logic        dir_run = DIR_UP;

    always #CLK_HALF i_clk = ~i_clk;

    initial begin
        int cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("Run timed out after %0d cycles.", cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        int hold_ack;
        int hold_left;
        hold_ack = 0;
        hold_left = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                res_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else if (hold_req != hold_ack) begin
                res_if.ready <= 1'b0;
                hold_ack = hold_req;
                hold_left = LONG_HOLD;
            end else begin
                res_if.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    function automatic aftoff_pkg::t_result result_of(int off, int freq, logic vfo, logic rr,
                                                      logic fast, int step_hz);
        aftoff_pkg::t_result r;
        r.offset_hz        = off[18:0];
        r.tuned_freq       = freq[26:0];
        r.vfo_slot         = vfo;
        r.recenter_request = rr;
        r.fast_active      = fast;
        r.step_in_use      = step_hz[13:0];
        return r;
    endfunction

    function automatic t_detent_row row(logic func, logic dir, logic [31:0] t, logic typed,
                                        aftoff_pkg::t_result want);
        t_detent_row d;
        d.func    = func;
        d.dir     = dir;
        d.time_ms = t;
        d.typed   = typed;
        d.want    = want;
        return d;
    endfunction

    function automatic t_tune_phase mk_phase(int step_hz, int center, int zoom, logic fte,
                                             logic vfo, t_idle_mode mode, int clr, int flip,
                                             int n);
        t_tune_phase p;
        p.regs.normal_step      = step_hz[13:0];
        p.regs.center_freq      = center[26:0];
        p.regs.zoom_level       = zoom[2:0];
        p.regs.fast_tune_enable = fte;
        p.regs.active_vfo       = vfo;
        p.mode                  = mode;
        p.clear_pct             = clr[6:0];
        p.flip_pct              = flip[6:0];
        p.n_items               = n[11:0];
        return p;
    endfunction

    function automatic aftoff_pkg::t_result predict_tune(logic func, logic dir,
                                                         logic [31:0] now);
        logic [31:0]         gap;
        logic [2:0]          cnt;
        int                  step_hz;
        int                  nxt;
        longint              freq;
        int                  win_hi;
        int                  win_lo;
        logic                outside;
        aftoff_pkg::t_result r;
        step_hz = 0;
        if (func == FUNC_CLEAR) begin
            tuned_offset = 0;
        end else begin
            gap = now - last_detent_ms;
            last_detent_ms = now;
            if (!regs_shadow.fast_tune_enable) begin
                fast_on = 1'b0;
            end else if (fast_on) begin
                if (gap >= aftoff_pkg::GAP_CANCEL_MS) fast_on = 1'b0;
            end else begin
                cnt = {1'b0, quick_cnt};
                if (gap <= aftoff_pkg::GAP_QUICK_MS) cnt = cnt + 3'd1;
                if (cnt >= aftoff_pkg::QUICK_TRIGGER) begin
                    cnt = '0;
                    fast_on = 1'b1;
                end
                quick_cnt = cnt[1:0];
            end
            step_hz = fast_on ? int'(aftoff_pkg::FAST_STEP) : int'(regs_shadow.normal_step);
            nxt = (dir == DIR_DOWN) ? tuned_offset - step_hz : tuned_offset + step_hz;
            if (nxt > int'(aftoff_pkg::OFFSET_MAX)) nxt = int'(aftoff_pkg::OFFSET_MAX);
            if (nxt < int'(aftoff_pkg::OFFSET_MIN)) nxt = int'(aftoff_pkg::OFFSET_MIN);
            tuned_offset = nxt;
        end
        freq = longint'(regs_shadow.center_freq) + tuned_offset;
        if (freq < 0) freq = 0;
        if (freq > longint'(aftoff_pkg::FREQ_MAX)) freq = longint'(aftoff_pkg::FREQ_MAX);
        if (regs_shadow.zoom_level != 3'd0) begin
            win_hi = int'(aftoff_pkg::WIN_HI_ZOOM);
            win_lo = int'(aftoff_pkg::WIN_LO_ZOOM);
            win_hi = win_hi >>> regs_shadow.zoom_level;
            win_lo = win_lo >>> regs_shadow.zoom_level;
            outside = (tuned_offset >= win_hi) || (tuned_offset < -win_lo);
        end else begin
            outside = (tuned_offset > int'(aftoff_pkg::WIN_HI_WIDE))
                   || (tuned_offset < int'(aftoff_pkg::WIN_LO_WIDE));
        end
        r = result_of(tuned_offset, int'(freq), regs_shadow.active_vfo, outside, fast_on,
                      step_hz);
        return r;
    endfunction

    task automatic check_tune(aftoff_pkg::t_result want);
        if (res_if.offset_hz !== want.offset_hz) begin
            $error("offset_hz: expected %0d, got %0d", want.offset_hz, res_if.offset_hz);
            mismatches++;
        end
        if (res_if.tuned_freq !== want.tuned_freq) begin
            $error("tuned_freq: expected %0d, got %0d", want.tuned_freq, res_if.tuned_freq);
            mismatches++;
        end
        if (res_if.vfo_slot !== want.vfo_slot) begin
            $error("vfo_slot: expected %0d, got %0d", want.vfo_slot, res_if.vfo_slot);
            mismatches++;
        end
        if (res_if.recenter_request !== want.recenter_request) begin
            $error("recenter_request: expected %0d, got %0d", want.recenter_request,
                   res_if.recenter_request);
            mismatches++;
        end
        if (res_if.fast_active !== want.fast_active) begin
            $error("fast_active: expected %0d, got %0d", want.fast_active, res_if.fast_active);
            mismatches++;
        end
        if (res_if.step_in_use !== want.step_in_use) begin
            $error("step_in_use: expected %0d, got %0d", want.step_in_use, res_if.step_in_use);
            mismatches++;
        end
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (expected_tunes.size() == 0) begin
                $error("Result request arrived with no expectation pending.");
                mismatches++;
            end else begin
                check_tune(expected_tunes.pop_front());
                results_checked++;
            end
        end
    end

    task automatic send_request(logic func, logic dir, logic [31:0] t, logic typed,
                                aftoff_pkg::t_result want);
        logic                took;
        aftoff_pkg::t_result exp_tune;
        while ($urandom_range(99) < tx_idle_pct) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid     <= 1'b1;
        item_if.func      <= func;
        item_if.direction <= dir;
        item_if.time_ms   <= t;
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = (item_if.ready === 1'b1);
            if (took) begin
                exp_tune = predict_tune(func, dir, t);
                if (typed) exp_tune = want;
                expected_tunes.push_back(exp_tune);
            end
            @(posedge i_clk);
        end
        requests_sent++;
    endtask

    task automatic send_random(t_tune_phase p);
        logic [31:0] gap;
        logic        func;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            gap = $urandom_range(30);
        end else if (pick < 55) begin
            case ($urandom_range(5))
                0: gap = 32'd29;
                1: gap = 32'd30;
                2: gap = 32'd31;
                3: gap = 32'd399;
                4: gap = 32'd400;
                default: gap = 32'd401;
            endcase
        end else if (pick < 70) begin
            gap = $urandom_range(399, 31);
        end else if (pick < 90) begin
            gap = $urandom_range(5000, 400);
        end else begin
            gap = $urandom - stamp_ms;
        end
        stamp_ms = stamp_ms + gap;
        func = ($urandom_range(99) < p.clear_pct) ? FUNC_CLEAR : FUNC_DETENT;
        if ($urandom_range(99) < p.flip_pct) dir_run = ~dir_run;
        send_request(func, dir_run, stamp_ms, 1'b0, '0);
    endtask

    task automatic write_reg(logic [aftoff_pkg::CFG_IDX_W-1:0] idx,
                             logic [aftoff_pkg::CFG_DATA_W-1:0] data);
        logic took;
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = (cfg_if.ready === 1'b1);
            @(posedge i_clk);
        end
        case (idx)
            aftoff_pkg::CFG_NORMAL_STEP:      regs_shadow.normal_step      = data[13:0];
            aftoff_pkg::CFG_CENTER_FREQ:      regs_shadow.center_freq      = data[26:0];
            aftoff_pkg::CFG_ZOOM_LEVEL:       regs_shadow.zoom_level       = data[2:0];
            aftoff_pkg::CFG_FAST_TUNE_ENABLE: regs_shadow.fast_tune_enable = data[0];
            aftoff_pkg::CFG_ACTIVE_VFO:       regs_shadow.active_vfo       = data[0];
            default: ;
        endcase
    endtask

    task automatic drain_results();
        item_if.valid <= 1'b0;
        while (expected_tunes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_tune_phase p;
        item_if.valid     = 1'b0;
        item_if.func      = FUNC_DETENT;
        item_if.direction = DIR_UP;
        item_if.time_ms   = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = aftoff_pkg::CFG_NORMAL_STEP;
        cfg_if.data       = '0;

        regs_shadow.normal_step      = aftoff_pkg::RST_NORMAL_STEP;
        regs_shadow.center_freq      = aftoff_pkg::RST_CENTER_FREQ;
        regs_shadow.zoom_level       = '0;
        regs_shadow.fast_tune_enable = 1'b1;
        regs_shadow.active_vfo       = 1'b0;
        tuned_offset   = 0;
        last_detent_ms = '0;
        fast_on        = 1'b0;
        quick_cnt      = '0;

        directed_rows = '{
            row(FUNC_DETENT, DIR_UP,   32'd0,         1'b1,
                result_of(50, 7100050, 1'b0, 1'b0, 1'b0, 50)),
            row(FUNC_CLEAR,  DIR_UP,   32'd123,       1'b1,
                result_of(0, 7100000, 1'b0, 1'b0, 1'b0, 0)),
            row(FUNC_DETENT, DIR_DOWN, 32'hFFFF_FFFF, 1'b1,
                result_of(-50, 7099950, 1'b0, 1'b0, 1'b0, 50)),
            row(FUNC_DETENT, DIR_UP,   32'd29,        1'b0, '0),
            row(FUNC_DETENT, DIR_UP,   32'd60,        1'b0, '0),
            row(FUNC_DETENT, DIR_UP,   32'd70,        1'b0, '0),
            row(FUNC_DETENT, DIR_UP,   32'd100,       1'b0, '0),
            row(FUNC_DETENT, DIR_DOWN, 32'd499,       1'b0, '0),
            row(FUNC_DETENT, DIR_DOWN, 32'd899,       1'b0, '0),
            row(FUNC_DETENT, DIR_UP,   32'd900,       1'b0, '0),
            row(FUNC_DETENT, DIR_UP,   32'd905,       1'b0, '0),
            row(FUNC_DETENT, DIR_UP,   32'd910,       1'b0, '0),
            row(FUNC_DETENT, DIR_UP,   32'd915,       1'b0, '0),
            row(FUNC_CLEAR,  DIR_UP,   32'd0,         1'b0, '0),
            row(FUNC_DETENT, DIR_UP,   32'd1314,      1'b0, '0),
            row(FUNC_DETENT, DIR_UP,   32'h8000_0000, 1'b0, '0),
            row(FUNC_DETENT, DIR_DOWN, 32'h7FFF_FFFF, 1'b0, '0),
            row(FUNC_DETENT, DIR_UP,   32'hAAAA_AAAA, 1'b0, '0),
            row(FUNC_DETENT, DIR_DOWN, 32'h5555_5555, 1'b0, '0),
            row(FUNC_CLEAR,  DIR_DOWN, 32'hFFFF_FFFF, 1'b1,
                result_of(0, 7100000, 1'b0, 1'b0, 1'b0, 0))
        };

        phases = '{
            mk_phase(50,    7100000,   0, 1'b1, 1'b0, IDLE_NONE,     5, 10, 250),
            mk_phase(1,     300000,    1, 1'b1, 1'b1, IDLE_SENDER,   5, 10, 200),
            mk_phase(10000, 100000000, 4, 1'b1, 1'b0, IDLE_RECEIVER, 1, 3,  200),
            mk_phase(16383, 0,         7, 1'b0, 1'b1, IDLE_BOTH,     1, 3,  200),
            mk_phase(16383, 134217727, 2, 1'b0, 1'b0, IDLE_NONE,     1, 3,  150),
            mk_phase(0,     5000000,   3, 1'b1, 1'b1, IDLE_SENDER,   5, 10, 150),
            mk_phase(777,   14000000,  5, 1'b0, 1'b0, IDLE_RECEIVER, 5, 10, 200),
            mk_phase(1000,  28000000,  0, 1'b1, 1'b1, IDLE_BOTH,     3, 5,  250),
            mk_phase(250,   7100000,   6, 1'b1, 1'b0, IDLE_NONE,     5, 10, 230)
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_request(directed_rows[i].func, directed_rows[i].dir, directed_rows[i].time_ms,
                         directed_rows[i].typed, directed_rows[i].want);
        end
        stamp_ms = directed_rows[N_DIRECTED-1].time_ms;
        drain_results();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            p = phases[ph];
            write_reg(aftoff_pkg::CFG_NORMAL_STEP, CFG_W'(p.regs.normal_step));
            write_reg(aftoff_pkg::CFG_CENTER_FREQ, p.regs.center_freq);
            write_reg(aftoff_pkg::CFG_ZOOM_LEVEL, CFG_W'(p.regs.zoom_level));
            write_reg(aftoff_pkg::CFG_FAST_TUNE_ENABLE, CFG_W'(p.regs.fast_tune_enable));
            write_reg(aftoff_pkg::CFG_ACTIVE_VFO, CFG_W'(p.regs.active_vfo));
            cfg_if.valid <= 1'b0;
            case (p.mode)
                IDLE_NONE:     begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                IDLE_SENDER:   begin tx_idle_pct = 73; rx_stall_pct = 0;  end
                IDLE_RECEIVER: begin tx_idle_pct = 0;  rx_stall_pct = 73; end
                default:       begin tx_idle_pct = 33; rx_stall_pct = 33; end
            endcase
            if (ph == HOLD_PHASE) hold_req <= hold_req + 1;
            for (int n = 0; n < int'(p.n_items); n++) send_random(p);
            drain_results();
        end

        if (expected_tunes.size() != 0) begin
            $error("%0d expected results never arrived.", expected_tunes.size());
        end
        $display("Sent %0d requests (%0d directed) across %0d register settings.",
                 requests_sent, N_DIRECTED, N_PHASES);
        $display("Checked %0d results, %0d field mismatches.", results_checked, mismatches);
        if (mismatches == 0 && expected_tunes.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
